@@ sv/lsm_pkg.sv @@
// ----------------------------------------------------------------------------
// lsm_pkg
// widths and types shared by the least-squares multilateration pipeline
// ----------------------------------------------------------------------------
package lsm_pkg;

    localparam int RW    = 16;   // range input width
    localparam int CW    = 16;   // anchor coordinate width
    localparam int NREG  = 8;    // number of anchor registers
    localparam int NANC  = 4;    // number of anchors
    localparam int AIW   = 3;    // anchor register index width
    localparam int PAW   = 5;    // apb address width
    localparam int PDATW = 32;   // apb data width
    localparam int SQW   = 32;   // square of a range or anchor norm
    localparam int EW    = 17;   // edge component
    localparam int Y2W   = 34;   // twice the linear coefficient
    localparam int PXW   = 34;   // edge component product
    localparam int ABW   = 36;   // normal matrix entries
    localparam int PUW   = 51;   // edge times coefficient
    localparam int UW    = 53;   // right-hand side entries
    localparam int DSPL  = 18;   // split point of normal matrix operand
    localparam int USPL  = 27;   // split point of right-hand side operand
    localparam int PDW   = 56;   // determinant partial products
    localparam int PNW   = 65;   // numerator partial products
    localparam int DETW  = 74;   // determinant
    localparam int DENW  = 75;   // divisor (twice the determinant)
    localparam int NUMW  = 92;   // numerator
    localparam int QW    = 33;   // quotient bits before saturation
    localparam int POSW  = 32;   // position width

    typedef logic signed [CW-1:0] t_coord;
    typedef logic [RW-1:0]        t_range;
    typedef logic signed [EW-1:0] t_edge;

endpackage

@@ sv/least_squares_multilateration.sv @@
// ----------------------------------------------------------------------------
// least_squares_multilateration
// 2d position from four anchor ranges by linearized ordinary least squares
// ----------------------------------------------------------------------------
// pipeline: start to o_valid passes 7 solver stages, 35 divider
//   stages and one output register; the divider takes one quotient bit a stage
// throughput: one transaction per cycle, busy stays low
// reset: synchronous active-low i_rst_n clears the anchors to zero and
//   drops every in-flight transaction
module least_squares_multilateration #(
    parameter int FRAC_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lsm_pkg::PAW-1:0]         paddr,
    input  logic [lsm_pkg::PDATW-1:0]       pwdata,
    output logic [lsm_pkg::PDATW-1:0]       prdata,
    output logic                            pready,
    input  logic                            start,
    output logic                            busy,
    input  logic [lsm_pkg::RW-1:0]          i_range0,
    input  logic [lsm_pkg::RW-1:0]          i_range1,
    input  logic [lsm_pkg::RW-1:0]          i_range2,
    input  logic [lsm_pkg::RW-1:0]          i_range3,
    output logic                            o_valid,
    output logic signed [lsm_pkg::POSW-1:0] o_pos_x,
    output logic signed [lsm_pkg::POSW-1:0] o_pos_y,
    output logic                            o_status
);
    import lsm_pkg::*;

    localparam int DIVLAT = QW + 2;
    localparam int NSTG   = 8 + DIVLAT;

    // configuration
    t_coord r_anc [NREG];
    logic   wr_en;
    logic [AIW-1:0] wr_idx;
    logic [AIW-1:0] rd_idx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = paddr[PAW-1:2];
    assign rd_idx = paddr[PAW-1:2];
    assign prdata = PDATW'(r_anc[rd_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NREG; i++) begin
                r_anc[i] <= '0;
            end
        end else if (wr_en) begin
            r_anc[wr_idx] <= t_coord'(pwdata[CW-1:0]);
        end
    end

    // valid chain
    logic [NSTG-1:0] r_vld;
    logic            accept;

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], accept};
        end
    end

    // stage 1: squares and edges
    t_range            rng [NANC];
    logic [SQW-1:0]    n_rsq [NANC];
    logic [SQW-1:0]    n_asq [NANC];
    t_edge             n_ex [NANC-1];
    t_edge             n_ey [NANC-1];
    logic [SQW-1:0]    r_rsq [NANC];
    logic [SQW-1:0]    r_asq [NANC];
    t_edge             r1_ex [NANC-1];
    t_edge             r1_ey [NANC-1];

    assign rng[0] = i_range0;
    assign rng[1] = i_range1;
    assign rng[2] = i_range2;
    assign rng[3] = i_range3;

    always_comb begin
        for (int i = 0; i < NANC; i++) begin
            n_rsq[i] = SQW'(rng[i]) * SQW'(rng[i]);
            n_asq[i] = SQW'(33'(r_anc[2*i]) * 33'(r_anc[2*i])
                          + 33'(r_anc[2*i+1]) * 33'(r_anc[2*i+1]));
        end
        for (int i = 0; i < NANC - 1; i++) begin
            n_ex[i] = EW'(r_anc[2*i+2]) - EW'(r_anc[0]);
            n_ey[i] = EW'(r_anc[2*i+3]) - EW'(r_anc[1]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsq <= n_rsq;
        r_asq <= n_asq;
        r1_ex <= n_ex;
        r1_ey <= n_ey;
    end

    // stage 2: coefficients and edge products
    logic signed [Y2W-1:0] n_y2 [NANC-1];
    logic signed [PXW-1:0] n_pxx [NANC-1];
    logic signed [PXW-1:0] n_pxy [NANC-1];
    logic signed [PXW-1:0] n_pyy [NANC-1];
    logic signed [Y2W-1:0] r_y2 [NANC-1];
    logic signed [PXW-1:0] r_pxx [NANC-1];
    logic signed [PXW-1:0] r_pxy [NANC-1];
    logic signed [PXW-1:0] r_pyy [NANC-1];
    t_edge                 r2_ex [NANC-1];
    t_edge                 r2_ey [NANC-1];

    always_comb begin
        for (int i = 0; i < NANC - 1; i++) begin
            n_y2[i]  = $signed(Y2W'(r_rsq[0])) - $signed(Y2W'(r_rsq[i+1]))
                     + $signed(Y2W'(r_asq[i+1])) - $signed(Y2W'(r_asq[0]));
            n_pxx[i] = PXW'(r1_ex[i]) * PXW'(r1_ex[i]);
            n_pxy[i] = PXW'(r1_ex[i]) * PXW'(r1_ey[i]);
            n_pyy[i] = PXW'(r1_ey[i]) * PXW'(r1_ey[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_y2  <= n_y2;
        r_pxx <= n_pxx;
        r_pxy <= n_pxy;
        r_pyy <= n_pyy;
        r2_ex <= r1_ex;
        r2_ey <= r1_ey;
    end

    // stage 3: normal matrix and right-hand side products
    logic signed [ABW-1:0] n3_a, n3_b, n3_d;
    logic signed [PUW-1:0] n_pu [NANC-1];
    logic signed [PUW-1:0] n_pv [NANC-1];
    logic signed [ABW-1:0] r3_a, r3_b, r3_d;
    logic signed [PUW-1:0] r_pu [NANC-1];
    logic signed [PUW-1:0] r_pv [NANC-1];

    always_comb begin
        n3_a = ABW'(r_pxx[0]) + ABW'(r_pxx[1]) + ABW'(r_pxx[2]);
        n3_b = ABW'(r_pxy[0]) + ABW'(r_pxy[1]) + ABW'(r_pxy[2]);
        n3_d = ABW'(r_pyy[0]) + ABW'(r_pyy[1]) + ABW'(r_pyy[2]);
        for (int i = 0; i < NANC - 1; i++) begin
            n_pu[i] = PUW'(r2_ex[i]) * PUW'(r_y2[i]);
            n_pv[i] = PUW'(r2_ey[i]) * PUW'(r_y2[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r3_a <= n3_a;
        r3_b <= n3_b;
        r3_d <= n3_d;
        r_pu <= n_pu;
        r_pv <= n_pv;
    end

    // stage 4: right-hand side sums
    logic signed [ABW-1:0] r4_a, r4_b, r4_d;
    logic signed [UW-1:0]  r4_u, r4_v;

    always_ff @(posedge i_clk) begin
        r4_a <= r3_a;
        r4_b <= r3_b;
        r4_d <= r3_d;
        r4_u <= UW'(r_pu[0]) + UW'(r_pu[1]) + UW'(r_pu[2]);
        r4_v <= UW'(r_pv[0]) + UW'(r_pv[1]) + UW'(r_pv[2]);
    end

    // stage 5: split partial products
    logic signed [DSPL:0]        d_lo, b_lo;
    logic signed [ABW-DSPL-1:0]  d_hi, b_hi;
    logic signed [USPL:0]        u_lo, v_lo;
    logic signed [UW-USPL-1:0]   u_hi, v_hi;
    logic signed [PDW-1:0] r_ad_h, r_ad_l, r_bb_h, r_bb_l;
    logic signed [PNW-1:0] r_du_h, r_du_l, r_bv_h, r_bv_l;
    logic signed [PNW-1:0] r_av_h, r_av_l, r_bu_h, r_bu_l;

    always_comb begin
        d_lo = $signed({1'b0, r4_d[DSPL-1:0]});
        d_hi = $signed(r4_d[ABW-1:DSPL]);
        b_lo = $signed({1'b0, r4_b[DSPL-1:0]});
        b_hi = $signed(r4_b[ABW-1:DSPL]);
        u_lo = $signed({1'b0, r4_u[USPL-1:0]});
        u_hi = $signed(r4_u[UW-1:USPL]);
        v_lo = $signed({1'b0, r4_v[USPL-1:0]});
        v_hi = $signed(r4_v[UW-1:USPL]);
    end

    always_ff @(posedge i_clk) begin
        r_ad_h <= PDW'(r4_a) * PDW'(d_hi);
        r_ad_l <= PDW'(r4_a) * PDW'(d_lo);
        r_bb_h <= PDW'(r4_b) * PDW'(b_hi);
        r_bb_l <= PDW'(r4_b) * PDW'(b_lo);
        r_du_h <= PNW'(r4_d) * PNW'(u_hi);
        r_du_l <= PNW'(r4_d) * PNW'(u_lo);
        r_bv_h <= PNW'(r4_b) * PNW'(v_hi);
        r_bv_l <= PNW'(r4_b) * PNW'(v_lo);
        r_av_h <= PNW'(r4_a) * PNW'(v_hi);
        r_av_l <= PNW'(r4_a) * PNW'(v_lo);
        r_bu_h <= PNW'(r4_b) * PNW'(u_hi);
        r_bu_l <= PNW'(r4_b) * PNW'(u_lo);
    end

    // stage 6: partial differences
    logic signed [PDW-1:0] r_det_h, r_det_l;
    logic signed [PNW-1:0] r_nx_h, r_nx_l, r_ny_h, r_ny_l;

    always_ff @(posedge i_clk) begin
        r_det_h <= r_ad_h - r_bb_h;
        r_det_l <= r_ad_l - r_bb_l;
        r_nx_h  <= r_du_h - r_bv_h;
        r_nx_l  <= r_du_l - r_bv_l;
        r_ny_h  <= r_av_h - r_bu_h;
        r_ny_l  <= r_av_l - r_bu_l;
    end

    // stage 7: determinant and numerators
    logic signed [DETW-1:0] r_det;
    logic signed [NUMW-1:0] r_nx, r_ny;

    always_ff @(posedge i_clk) begin
        r_det <= (DETW'(r_det_h) <<< DSPL) + DETW'(r_det_l);
        r_nx  <= (NUMW'(r_nx_h) <<< USPL) + NUMW'(r_nx_l);
        r_ny  <= (NUMW'(r_ny_h) <<< USPL) + NUMW'(r_ny_l);
    end

    // dividers
    logic [DENW-1:0]        den;
    logic signed [POSW-1:0] quo_x, quo_y;
    logic [DIVLAT-1:0]      r_sing;

    assign den = {r_det[DETW-1:0], 1'b0};

    lsm_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_x (
        .i_clk (i_clk),
        .i_num (r_nx),
        .i_den (den),
        .o_quo (quo_x)
    );

    lsm_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_y (
        .i_clk (i_clk),
        .i_num (r_ny),
        .i_den (den),
        .o_quo (quo_y)
    );

    always_ff @(posedge i_clk) begin
        r_sing <= {r_sing[DIVLAT-2:0], (r_det == '0)};
    end

    // output register
    logic signed [POSW-1:0] r_pos_x, r_pos_y;
    logic                   r_status;

    always_ff @(posedge i_clk) begin
        r_pos_x  <= r_sing[DIVLAT-1] ? '0 : quo_x;
        r_pos_y  <= r_sing[DIVLAT-1] ? '0 : quo_y;
        r_status <= r_sing[DIVLAT-1];
    end

    assign o_valid  = r_vld[NSTG-1];
    assign o_pos_x  = r_pos_x;
    assign o_pos_y  = r_pos_y;
    assign o_status = r_status;

endmodule

@@ sv/lsm_div.sv @@
// ----------------------------------------------------------------------------
// lsm_div
// pipelined restoring divider, one quotient bit per stage, with truncation
// toward zero and saturation to a signed 32-bit fixed-point position
// ----------------------------------------------------------------------------
module lsm_div #(
    parameter int FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic signed [lsm_pkg::NUMW-1:0]   i_num,
    input  logic [lsm_pkg::DENW-1:0]          i_den,
    output logic signed [lsm_pkg::POSW-1:0]   o_quo
);
    import lsm_pkg::*;

    localparam int MAGW = NUMW + FRAC_BITS;
    localparam int DW   = (MAGW > DENW + QW + 1) ? MAGW : DENW + QW + 1;
    localparam logic [QW-1:0] LIM_POS = QW'((64'd1 << (POSW - 1)) - 64'd1);
    localparam logic [QW-1:0] LIM_NEG = QW'(64'd1 << (POSW - 1));

    logic [DW-1:0]   r_rem [QW+1];
    logic [DENW-1:0] r_den [QW+1];
    logic [QW-1:0]   r_q   [QW+1];
    logic            r_neg [QW+1];
    logic            r_ov  [QW+1];
    logic [POSW-1:0] r_out;

    logic [NUMW-1:0] mag;
    logic [DW-1:0]   mag_sh;
    logic [DW-1:0]   den_top;

    always_comb begin
        mag     = i_num[NUMW-1] ? NUMW'(-i_num) : NUMW'(i_num);
        mag_sh  = DW'(mag) << FRAC_BITS;
        den_top = DW'(i_den) << QW;
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= mag_sh;
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_neg[0] <= i_num[NUMW-1];
        r_ov[0]  <= (mag_sh >= den_top);
    end

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int K = QW - 1 - j;
        logic [DW-1:0] trial;
        logic          ge;
        always_comb begin
            trial = DW'(r_den[j]) << K;
            ge    = (r_rem[j] >= trial);
        end
        always_ff @(posedge i_clk) begin
            r_rem[j+1] <= ge ? (r_rem[j] - trial) : r_rem[j];
            r_den[j+1] <= r_den[j];
            r_q[j+1]   <= r_q[j] | (ge ? (QW'(1) << K) : QW'(0));
            r_neg[j+1] <= r_neg[j];
            r_ov[j+1]  <= r_ov[j];
        end
    end

    logic [QW-1:0]   lim;
    logic [QW-1:0]   qv;
    logic [POSW-1:0] mag_out;

    always_comb begin
        lim     = r_neg[QW] ? LIM_NEG : LIM_POS;
        qv      = (r_ov[QW] || (r_q[QW] > lim)) ? lim : r_q[QW];
        mag_out = qv[POSW-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_out <= r_neg[QW] ? (POSW'(0) - mag_out) : mag_out;
    end

    assign o_quo = $signed(r_out);

endmodule

@@ sim/least_squares_multilateration_tb.sv @@
// ----------------------------------------------------------------------------
// least_squares_multilateration_tb
// drives range sets under several anchor layouts and compares each position
// fix against an exact integer least-squares solution computed in the bench
// ----------------------------------------------------------------------------
module least_squares_multilateration_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsm_pkg::*;

    localparam int LATENCY  = 43;
    localparam int WDOG_MAX = 20000;
    localparam int FRAC_W   = 8;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic               status;
    } t_fix;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [PAW-1:0]   paddr = '0;
    logic [PDATW-1:0] pwdata = '0;
    logic [PDATW-1:0] prdata;
    logic             pready;
    logic             start = 1'b0;
    logic             busy;
    logic [RW-1:0]    i_range0 = '0;
    logic [RW-1:0]    i_range1 = '0;
    logic [RW-1:0]    i_range2 = '0;
    logic [RW-1:0]    i_range3 = '0;
    logic             o_valid;
    logic signed [31:0] o_pos_x;
    logic signed [31:0] o_pos_y;
    logic             o_status;

    t_coord anchor_q [NREG];
    t_fix   fix_queue [$];
    int     err_count = 0;
    int     idle_cycles = 0;

    least_squares_multilateration u_dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic logic signed [31:0] fixed_quotient(logic signed [127:0] num,
                                                        logic signed [127:0] den);
        logic        neg;
        logic [127:0] mag;
        logic [127:0] q;
        neg = num < 0;
        mag = neg ? -num : num;
        q = (mag << FRAC_W) / den;
        if (neg) begin
            if (q > 128'h8000_0000) q = 128'h8000_0000;
            return -q[31:0];
        end
        if (q > 128'h7fff_ffff) q = 128'h7fff_ffff;
        return q[31:0];
    endfunction

    function automatic t_fix solve_position(t_range r [4]);
        logic signed [127:0] a, b, d, u, v, ex, ey, y2, n0, det, r0, ri, ax, ay;
        t_fix f;
        a = 0; b = 0; d = 0; u = 0; v = 0;
        r0 = r[0];
        n0 = anchor_q[0] * anchor_q[0] + anchor_q[1] * anchor_q[1];
        for (int i = 1; i < 4; i++) begin
            ax = anchor_q[2*i];
            ay = anchor_q[2*i+1];
            ex = ax - anchor_q[0];
            ey = ay - anchor_q[1];
            ri = r[i];
            y2 = r0 * r0 - ri * ri + ax * ax + ay * ay - n0;
            a += ex * ex; b += ex * ey; d += ey * ey;
            u += ex * y2; v += ey * y2;
        end
        det = a * d - b * b;
        f = '0;
        if (det == 0) begin
            f.status = 1'b1;
            return f;
        end
        f.pos_x = fixed_quotient(d * u - b * v, det * 2);
        f.pos_y = fixed_quotient(a * v - b * u, det * 2);
        return f;
    endfunction

    always @(posedge i_clk) begin
        t_fix exp_fix;
        if (o_valid) begin
            if (fix_queue.size() == 0) begin
                $error("unexpected transaction");
                err_count++;
            end else begin
                exp_fix = fix_queue.pop_front();
                if (o_pos_x !== exp_fix.pos_x) begin
                    $error("pos_x expected %0d actual %0d", exp_fix.pos_x, o_pos_x);
                    err_count++;
                end
                if (o_pos_y !== exp_fix.pos_y) begin
                    $error("pos_y expected %0d actual %0d", exp_fix.pos_y, o_pos_y);
                    err_count++;
                end
                if (o_status !== exp_fix.status) begin
                    $error("status expected %0d actual %0d", exp_fix.status, o_status);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (o_valid || (start && !busy) || (psel && penable)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_anchor(int idx, t_coord val);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = PAW'(4 * idx); pwdata = {{16{val[15]}}, val};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        anchor_q[idx] = val;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic set_anchors(t_coord c [NREG]);
        for (int i = 0; i < NREG; i++) write_anchor(i, c[i]);
    endtask

    task automatic drain_fixes();
        while (fix_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_ranges(t_range r [4], bit gaps);
        int g;
        @(negedge i_clk);
        if (gaps) begin
            g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
                ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
            start = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        start = 1'b1;
        i_range0 = r[0]; i_range1 = r[1]; i_range2 = r[2]; i_range3 = r[3];
        do @(posedge i_clk); while (busy);
        fix_queue.push_back(solve_position(r));
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic test_reset_singular();
        t_range r [4];
        r = '{16'd0, 16'd0, 16'd0, 16'd0};
        send_ranges(r, 0);
        r = '{16'hffff, 16'd1, 16'h8000, 16'h7fff};
        send_ranges(r, 0);
        end_burst();
        drain_fixes();
    endtask

    task automatic test_directed();
        t_coord c [NREG];
        t_range r [4];
        c = '{0, 0, 100, 0, 0, 100, 100, 100};
        set_anchors(c);
        r = '{16'd0, 16'd100, 16'd100, 16'd141};
        send_ranges(r, 0);
        r = '{16'd71, 16'd71, 16'd71, 16'd71};
        send_ranges(r, 0);
        r = '{16'hffff, 16'h0, 16'h0, 16'h0};
        send_ranges(r, 0);
        r = '{16'h0, 16'hffff, 16'hffff, 16'hffff};
        send_ranges(r, 0);
        end_burst();
        drain_fixes();
        c = '{-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767};
        set_anchors(c);
        r = '{16'hffff, 16'hffff, 16'hffff, 16'hffff};
        send_ranges(r, 0);
        r = '{16'h0, 16'hffff, 16'h0, 16'hffff};
        send_ranges(r, 0);
        r = '{16'hffff, 16'h0, 16'hffff, 16'h0};
        send_ranges(r, 0);
        end_burst();
        drain_fixes();
        // collinear anchors
        c = '{0, 0, 10, 10, -20, -20, 300, 300};
        set_anchors(c);
        r = '{16'd5, 16'd9, 16'd40, 16'd400};
        send_ranges(r, 0);
        end_burst();
        drain_fixes();
        // nearly collinear, overflow to saturation
        c = '{0, 0, 1, 0, 2, 0, 3, 1};
        set_anchors(c);
        r = '{16'hffff, 16'd0, 16'd0, 16'd0};
        send_ranges(r, 0);
        r = '{16'd0, 16'hffff, 16'hffff, 16'hffff};
        send_ranges(r, 0);
        r = '{16'd3, 16'd2, 16'd1, 16'd0};
        send_ranges(r, 0);
        end_burst();
        drain_fixes();
    endtask

    task automatic test_random();
        t_coord c [NREG];
        t_range r [4];
        for (int ph = 0; ph < 10; ph++) begin
            for (int i = 0; i < NREG; i++) begin
                case ($urandom_range(0, 3))
                    0: c[i] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                    1: c[i] = $signed(16'($urandom_range(0, 200))) - 16'sd100;
                    default: c[i] = t_coord'($urandom);
                endcase
            end
            if (ph == 3) c = '{5, 5, 5, 5, 5, 5, 5, 5};
            set_anchors(c);
            for (int n = 0; n < 100; n++) begin
                for (int k = 0; k < 4; k++)
                    r[k] = ($urandom_range(0, 3) == 0) ? RW'($urandom_range(0, 300))
                                                       : RW'($urandom);
                send_ranges(r, 1);
            end
            end_burst();
            drain_fixes();
        end
    endtask

    initial begin
        for (int i = 0; i < NREG; i++) anchor_q[i] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_singular();
        test_directed();
        test_random();
        if (err_count == 0 && fix_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
